@@ hdl/sha1sh_pkg.sv @@
`default_nettype none

package sha1sh_pkg;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_ZERO,
    S_LEN,
    S_COMP,
    S_DIGEST
  } state_e;

  // Controls from the sequencer to the round unit
  typedef struct packed {
    logic start;   // block complete, begin 80 rounds
    logic reinit;  // reload the initial chaining values
  } rnd_ctrl_t;

  localparam logic [4:0][31:0] IV_WORDS = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PA2 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] LEN_AT     = 6'd56;
  localparam logic [2:0] LEN_LAST   = 3'd7;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    case (rnd) inside
      [7'd0:7'd19]:  k = K_CH;
      [7'd20:7'd39]: k = K_PA1;
      [7'd40:7'd59]: k = K_MAJ;
      default:       k = K_PA2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (rnd) inside
      [7'd0:7'd19]:  f = (b & c) | (~b & d);
      [7'd40:7'd59]: f = (b & c) | (b & d) | (c & d);
      default:       f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sha1sh_stream_if.sv @@
`default_nettype none

interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte, output end_of_message,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input end_of_message,
                  output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/sha1sh_sched.sv @@
`default_nettype none

// Block buffer and message schedule in one 16-word shift line.
// Bytes shift in at the bottom; during rounds words shift out of the top
// and the expanded word enters at the bottom.
module sha1sh_sched (
  input  wire logic        clk_i,
  input  wire logic        push_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        shift_i,
  output logic      [31:0] word_o
);

  logic [15:0][31:0] w_q, w_d;
  logic [31:0]       mix;

  // word j of the block sits at w_q[15 - j]
  assign mix    = w_q[2] ^ w_q[7] ^ w_q[13] ^ w_q[15];
  assign word_o = w_q[15];

  always_comb begin
    w_d = w_q;
    if (push_i) begin
      w_d = {w_q[15][23:0], w_q[14:0], byte_i};
    end else if (shift_i) begin
      w_d = {w_q[14:0], mix[30:0], mix[31]};
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

endmodule

`default_nettype wire

@@ hdl/sha1sh_round.sv @@
`default_nettype none

// Shared round unit: one SHA-1 round per cycle for 80 rounds, then a fold of
// the working words into the chaining words.
module sha1sh_round (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sha1sh_pkg::rnd_ctrl_t ctrl_i,
  input  wire logic [31:0]           word_i,
  output logic                       shift_o,
  output logic                       done_o,
  output logic [4:0][31:0]           chain_o
);

  logic [4:0][31:0] chain_q, chain_d;
  logic [4:0][31:0] work_q, work_d;   // a..e at index 0..4
  logic [6:0]       rnd_q, rnd_d;
  logic             busy_q, busy_d;
  logic             fin_q, fin_d;
  logic [31:0]      t_val;

  assign t_val = {work_q[0][26:0], work_q[0][31:27]}
               + sha1sh_pkg::round_f(rnd_q, work_q[1], work_q[2], work_q[3])
               + work_q[4] + sha1sh_pkg::round_k(rnd_q) + word_i;

  assign shift_o = busy_q & ~fin_q;
  assign done_o  = fin_q;
  assign chain_o = chain_q;

  always_comb begin
    chain_d = chain_q;
    work_d  = work_q;
    rnd_d   = rnd_q;
    busy_d  = busy_q;
    fin_d   = fin_q;
    if (ctrl_i.reinit) begin
      chain_d = sha1sh_pkg::IV_WORDS;
    end
    if (ctrl_i.start) begin
      work_d = chain_q;
      rnd_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q && !fin_q) begin
      work_d[0] = t_val;
      work_d[1] = work_q[0];
      work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
      work_d[3] = work_q[2];
      work_d[4] = work_q[3];
      if (rnd_q == sha1sh_pkg::LAST_ROUND) begin
        fin_d = 1'b1;
      end else begin
        rnd_d = rnd_q + 7'd1;
      end
    end else if (fin_q) begin
      for (int i = 0; i < 5; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
      fin_d  = 1'b0;
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha1sh_pkg::IV_WORDS;
      rnd_q   <= '0;
      busy_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      chain_q <= chain_d;
      rnd_q   <= rnd_d;
      busy_q  <= busy_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

endmodule

`default_nettype wire

@@ hdl/sha1_stream_hasher_top.sv @@
`default_nettype none

// Channel  Dir  Beat contents                              Accepted when
// msg_i    in   data_byte, has_byte, end_of_message        valid & ready
// dig_o    out  digest_word, word_index, last_word         valid & ready
//
// Each byte beat fills the block buffer; the 64th byte of a block starts the
// compression, 80 rounds plus a fold on the shared round unit, during which
// msg_i is not ready.
// End of message: one padding or length byte per cycle (up to 64, or 72
// when the tail spills into a second block) except during compression,
// plus a turn state before the length and a compression per padded block,
// then five digest beats. Reset loads the initial chaining values, no clearing
// pass. A stall on dig_o holds the current digest word; msg_i stays low.
module sha1_stream_hasher_top (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sha1sh_in_if.sink     msg_i,
  sha1sh_out_if.source  dig_o
);

  sha1sh_pkg::state_e    state_q, state_d;
  sha1sh_pkg::state_e    after_q, after_d;   // where to resume after a block
  sha1sh_pkg::rnd_ctrl_t rnd_ctrl;

  logic [5:0]       fill_q, fill_d;
  logic [63:0]      len_q, len_d;           // message length in bytes
  logic [2:0]       len_idx_q, len_idx_d;
  logic [2:0]       word_idx_q, word_idx_d;
  logic [63:0]      bit_len;
  logic             in_beat, out_beat, out_final;
  logic             push;
  logic [7:0]       push_byte;
  logic             blk_full;
  logic             sched_shift;
  logic             rnd_done;
  logic [31:0]      sched_word;
  logic [4:0][31:0] chain;

  assign bit_len   = {len_q[60:0], 3'b000};
  assign in_beat   = msg_i.valid & msg_i.ready;
  assign out_beat  = dig_o.valid & dig_o.ready;
  assign out_final = out_beat & (word_idx_q == sha1sh_pkg::WORD_LAST);
  assign blk_full  = push & (fill_q == sha1sh_pkg::BLOCK_LAST);

  assign rnd_ctrl.start  = blk_full;
  assign rnd_ctrl.reinit = out_final;

  // beat outputs and byte pushes
  always_comb begin
    msg_i.ready = 1'b0;
    dig_o.valid = 1'b0;
    push        = 1'b0;
    push_byte   = sha1sh_pkg::ZERO_BYTE;
    case (state_q)
      sha1sh_pkg::S_IDLE: begin
        // ready is high throughout idle, so valid alone marks a beat
        msg_i.ready = 1'b1;
        push        = msg_i.valid & msg_i.has_byte;
        push_byte   = msg_i.data_byte;
      end
      sha1sh_pkg::S_PAD80: begin
        push      = 1'b1;
        push_byte = sha1sh_pkg::PAD_BYTE;
      end
      sha1sh_pkg::S_ZERO: begin
        push = (fill_q != sha1sh_pkg::LEN_AT);
      end
      sha1sh_pkg::S_LEN: begin
        push      = 1'b1;
        push_byte = bit_len[8 * (3'd7 - len_idx_q) +: 8];
      end
      sha1sh_pkg::S_DIGEST: begin
        dig_o.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign dig_o.digest_word = chain[word_idx_q];
  assign dig_o.word_index  = word_idx_q;
  assign dig_o.last_word   = (word_idx_q == sha1sh_pkg::WORD_LAST);

  // next state
  always_comb begin
    state_d = state_q;
    after_d = after_q;
    case (state_q)
      sha1sh_pkg::S_IDLE: begin
        if (in_beat) begin
          if (blk_full) begin
            state_d = sha1sh_pkg::S_COMP;
            after_d = msg_i.end_of_message ? sha1sh_pkg::S_PAD80 : sha1sh_pkg::S_IDLE;
          end else if (msg_i.end_of_message) begin
            state_d = sha1sh_pkg::S_PAD80;
          end
        end
      end
      sha1sh_pkg::S_PAD80: begin
        if (blk_full) begin
          state_d = sha1sh_pkg::S_COMP;
          after_d = sha1sh_pkg::S_ZERO;
        end else begin
          state_d = sha1sh_pkg::S_ZERO;
        end
      end
      sha1sh_pkg::S_ZERO: begin
        if (fill_q == sha1sh_pkg::LEN_AT) begin
          state_d = sha1sh_pkg::S_LEN;
        end else if (blk_full) begin
          state_d = sha1sh_pkg::S_COMP;
          after_d = sha1sh_pkg::S_ZERO;
        end
      end
      sha1sh_pkg::S_LEN: begin
        if (len_idx_q == sha1sh_pkg::LEN_LAST) begin
          state_d = sha1sh_pkg::S_COMP;
          after_d = sha1sh_pkg::S_DIGEST;
        end
      end
      sha1sh_pkg::S_COMP: begin
        if (rnd_done) begin
          state_d = after_q;
        end
      end
      sha1sh_pkg::S_DIGEST: begin
        if (out_final) begin
          state_d = sha1sh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sha1sh_pkg::S_IDLE;
      end
    endcase
  end

  // counters
  always_comb begin
    fill_d     = push ? fill_q + 6'd1 : fill_q;
    len_d      = len_q;
    len_idx_d  = len_idx_q;
    word_idx_d = word_idx_q;
    if (state_q == sha1sh_pkg::S_IDLE && push) begin
      len_d = len_q + 64'd1;
    end
    if (state_q == sha1sh_pkg::S_LEN) begin
      len_idx_d = len_idx_q + 3'd1;
    end
    if (out_beat) begin
      word_idx_d = out_final ? 3'd0 : word_idx_q + 3'd1;
    end
    if (out_final) begin
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha1sh_pkg::S_IDLE;
      after_q    <= sha1sh_pkg::S_IDLE;
      fill_q     <= '0;
      len_q      <= '0;
      len_idx_q  <= '0;
      word_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      after_q    <= after_d;
      fill_q     <= fill_d;
      len_q      <= len_d;
      len_idx_q  <= len_idx_d;
      word_idx_q <= word_idx_d;
    end
  end

  sha1sh_sched u_sched (
    .clk_i   (clk_i),
    .push_i  (push),
    .byte_i  (push_byte),
    .shift_i (sched_shift),
    .word_o  (sched_word)
  );

  sha1sh_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rnd_ctrl),
    .word_i  (sched_word),
    .shift_o (sched_shift),
    .done_o  (rnd_done),
    .chain_o (chain)
  );

endmodule

`default_nettype wire
